/* hw/rtl/pwmt_pkg.sv */
// shared types, codes and match function for the post/wait match table
package pwmt_pkg;

    localparam logic [1:0] OP_POST          = 2'd0;
    localparam logic [1:0] OP_WAIT_ANY      = 2'd1;
    localparam logic [1:0] OP_WAIT_NODE     = 2'd2;
    localparam logic [1:0] OP_WAIT_NODE_TAG = 2'd3;

    localparam logic [2:0] ST_POSTED    = 3'd0;
    localparam logic [2:0] ST_MATCHED   = 3'd1;
    localparam logic [2:0] ST_PENDING   = 3'd2;
    localparam logic [2:0] ST_COMPLETED = 3'd3;
    localparam logic [2:0] ST_DROPPED   = 3'd4;
    localparam logic [2:0] ST_REJECTED  = 3'd5;

    localparam int NODE_W = 16;
    localparam int TAG_W  = 32;
    localparam int ENTRY_W = NODE_W + TAG_W;
    localparam int HELD_W = 7;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       clear_pending;
        logic       set_pending;
        logic       post_write;
        logic       shift_write;
        logic       count_inc;
        logic       count_dec;
        logic       ptr_load_top;
        logic       ptr_dec;
        logic       ptr_inc;
        logic       ram_read;
        logic       read_above;
        logic       hit_load;
        logic       res_load;
        logic [2:0] res_code;
        logic       out_load;
    } pwmt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       is_post;
        logic       pending;
        logic       post_fit;
        logic       full;
        logic       empty;
        logic       entry_fit;
        logic       ptr_zero;
        logic       above1;
        logic       above2;
        logic       out_free;
    } pwmt_stat_t;

    // does an entry satisfy a wait of this kind
    function automatic logic entry_fits(input logic [1:0] kind,
                                        input logic [NODE_W-1:0] want_node,
                                        input logic [TAG_W-1:0] want_tag,
                                        input logic [NODE_W-1:0] node,
                                        input logic [TAG_W-1:0] tag);
        logic fit;
        case (kind)
            OP_WAIT_ANY:  fit = 1'b1;
            OP_WAIT_NODE: fit = (node == want_node);
            default:      fit = (node == want_node) && (tag == want_tag);
        endcase
        return fit;
    endfunction

endpackage

/* hw/rtl/pwmt_ram.sv */
// generic simple dual port ram with registered read
module pwmt_ram #(
    parameter int DATA_WIDTH = 48,
    parameter int DEPTH      = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_WIDTH-1:0]    wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_WIDTH-1:0]    rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pwmt_datapath.sv */
// datapath: item capture, table storage, pointers, pending wait, result register
module pwmt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pwmt_pkg::pwmt_cmd_t         cmd,
    output pwmt_pkg::pwmt_stat_t        stat,
    input  logic [1:0]                  s_opcode,
    input  logic [pwmt_pkg::NODE_W-1:0] s_node_id,
    input  logic signed [pwmt_pkg::TAG_W-1:0] s_tag_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic [pwmt_pkg::NODE_W-1:0] m_matched_node,
    output logic signed [pwmt_pkg::TAG_W-1:0] m_matched_tag,
    output logic [pwmt_pkg::HELD_W-1:0] m_entries_held
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = pwmt_pkg::NODE_W;
    localparam int TW = pwmt_pkg::TAG_W;
    localparam int HW = pwmt_pkg::HELD_W;

    logic [1:0]    op_reg;
    logic [NW-1:0] node_reg;
    logic [TW-1:0] tag_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;

    logic          pend_reg, pend_next;
    logic [1:0]    pend_kind_reg, pend_kind_next;
    logic [NW-1:0] pend_node_reg, pend_node_next;
    logic [TW-1:0] pend_tag_reg, pend_tag_next;

    logic [2:0]    res_status_reg;
    logic [NW-1:0] res_node_reg;
    logic [TW-1:0] res_tag_reg;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg;
    logic [NW-1:0] m_node_reg;
    logic [TW-1:0] m_tag_reg;
    logic [HW-1:0] m_held_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [pwmt_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [pwmt_pkg::ENTRY_W-1:0] ram_rdata;
    logic [NW-1:0]                rd_node;
    logic [TW-1:0]                rd_tag;

    logic [CW:0]      ptr_ext;
    logic [CW:0]      count_ext;
    logic [CW+HW-1:0] count_wide;

    // table storage, one word per entry
    pwmt_ram #(
        .DATA_WIDTH (pwmt_pkg::ENTRY_W),
        .DEPTH      (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_read),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_node = ram_rdata[pwmt_pkg::ENTRY_W-1:TW];
    assign rd_tag  = ram_rdata[TW-1:0];

    assign ram_we    = cmd.post_write | cmd.shift_write;
    assign ram_waddr = cmd.post_write ? count_reg[AW-1:0] : ptr_reg;
    assign ram_wdata = cmd.post_write ? {node_reg, tag_reg} : ram_rdata;
    assign ram_raddr = cmd.read_above ? AW'(ptr_reg + AW'(1)) : ptr_reg;

    assign ptr_ext   = (CW + 1)'(ptr_reg);
    assign count_ext = {1'b0, count_reg};

    always_comb begin
        stat.is_post   = (op_reg == pwmt_pkg::OP_POST);
        stat.pending   = pend_reg;
        stat.post_fit  = pend_reg && pwmt_pkg::entry_fits(pend_kind_reg, pend_node_reg,
                                                         pend_tag_reg, node_reg, tag_reg);
        stat.full      = (count_reg >= CW'(TABLE_DEPTH));
        stat.empty     = (count_reg == '0);
        stat.entry_fit = pwmt_pkg::entry_fits(op_reg, node_reg, tag_reg, rd_node, rd_tag);
        stat.ptr_zero  = (ptr_reg == '0);
        stat.above1    = (ptr_ext + (CW + 1)'(1)) < count_ext;
        stat.above2    = (ptr_ext + (CW + 1)'(2)) < count_ext;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.count_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.count_dec) begin
            count_next = count_reg - CW'(1);
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_load_top) begin
            ptr_next = AW'(count_reg - CW'(1));
        end else if (cmd.ptr_dec) begin
            ptr_next = ptr_reg - AW'(1);
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + AW'(1);
        end

        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        pend_node_next = pend_node_reg;
        pend_tag_next  = pend_tag_reg;
        if (cmd.set_pending) begin
            pend_next      = 1'b1;
            pend_kind_next = op_reg;
            pend_node_next = node_reg;
            pend_tag_next  = tag_reg;
        end else if (cmd.clear_pending) begin
            pend_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_kind_reg <= '0;
            pend_node_reg <= '0;
            pend_tag_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            pend_kind_reg <= pend_kind_next;
            pend_node_reg <= pend_node_next;
            pend_tag_reg  <= pend_tag_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign count_wide = {{HW{1'b0}}, count_reg};

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_opcode;
            node_reg <= s_node_id;
            tag_reg  <= s_tag_value;
        end
        if (cmd.hit_load) begin
            res_node_reg <= rd_node;
            res_tag_reg  <= rd_tag;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_code;
            if (cmd.res_code == pwmt_pkg::ST_COMPLETED) begin
                res_node_reg <= node_reg;
                res_tag_reg  <= tag_reg;
            end else if (cmd.res_code != pwmt_pkg::ST_MATCHED) begin
                res_node_reg <= '0;
                res_tag_reg  <= '0;
            end
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_node_reg   <= res_node_reg;
            m_tag_reg    <= res_tag_reg;
            m_held_reg   <= count_wide[HW-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_matched_node = m_node_reg;
    assign m_matched_tag  = m_tag_reg;
    assign m_entries_held = m_held_reg;

endmodule

/* hw/rtl/pwmt_ctrl.sv */
// controller state machine: dispatch, newest-first search, shift down, result handoff
module pwmt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pwmt_pkg::pwmt_stat_t stat,
    output pwmt_pkg::pwmt_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SRD      = 3'd2;
    localparam logic [2:0] S_SCHK     = 3'd3;
    localparam logic [2:0] S_SHRD     = 3'd4;
    localparam logic [2:0] S_SHWR     = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_FINISH;
                if (stat.is_post) begin
                    cmd.res_load = 1'b1;
                    if (stat.post_fit) begin
                        cmd.clear_pending = 1'b1;
                        cmd.res_code      = pwmt_pkg::ST_COMPLETED;
                    end else if (stat.full) begin
                        cmd.res_code = pwmt_pkg::ST_DROPPED;
                    end else begin
                        cmd.post_write = 1'b1;
                        cmd.count_inc  = 1'b1;
                        cmd.res_code   = pwmt_pkg::ST_POSTED;
                    end
                end else if (stat.pending) begin
                    cmd.res_load = 1'b1;
                    cmd.res_code = pwmt_pkg::ST_REJECTED;
                end else if (stat.empty) begin
                    cmd.set_pending = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_code    = pwmt_pkg::ST_PENDING;
                end else begin
                    cmd.ptr_load_top = 1'b1;
                    state_next       = S_SRD;
                end
            end
            S_SRD: begin
                cmd.ram_read = 1'b1;
                state_next   = S_SCHK;
            end
            S_SCHK: begin
                if (stat.entry_fit) begin
                    cmd.hit_load = 1'b1;
                    if (stat.above1) begin
                        state_next = S_SHRD;
                    end else begin
                        cmd.count_dec = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_code  = pwmt_pkg::ST_MATCHED;
                        state_next    = S_FINISH;
                    end
                end else if (stat.ptr_zero) begin
                    cmd.set_pending = 1'b1;
                    cmd.res_load    = 1'b1;
                    cmd.res_code    = pwmt_pkg::ST_PENDING;
                    state_next      = S_FINISH;
                end else begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_SRD;
                end
            end
            S_SHRD: begin
                cmd.ram_read   = 1'b1;
                cmd.read_above = 1'b1;
                state_next     = S_SHWR;
            end
            S_SHWR: begin
                cmd.shift_write = 1'b1;
                cmd.ptr_inc     = 1'b1;
                if (stat.above2) begin
                    state_next = S_SHRD;
                end else begin
                    cmd.count_dec = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_code  = pwmt_pkg::ST_MATCHED;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/post_wait_match_table_core.sv */
// top level of the post/wait tag match table
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------------
// s_      | in        | s_valid / s_ready  | s_opcode, s_node_id, s_tag_value
// m_      | out       | m_valid / m_ready  | m_status, m_matched_node, m_matched_tag,
//         |           |                    | m_entries_held
//
// one item at a time; a post is resolved in the dispatch state and then handed to the output register
// a wait searches the table newest first and shifts the entries above a hit down,
// one entry at a time through the single read port of the table ram
// reset: aresetn synchronous active low, clears table count and pending wait;
// table contents are not cleared since only entries below the count are read
// a result waiting on m_ready does not block the next accept; the next item only
// stalls in its last cycle until the output register is free
module post_wait_match_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // item input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_opcode,
    input  logic [pwmt_pkg::NODE_W-1:0] s_node_id,
    input  logic signed [pwmt_pkg::TAG_W-1:0] s_tag_value,
    // result output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic [pwmt_pkg::NODE_W-1:0] m_matched_node,
    output logic signed [pwmt_pkg::TAG_W-1:0] m_matched_tag,
    output logic [pwmt_pkg::HELD_W-1:0] m_entries_held
);

    // command and status between controller and datapath
    pwmt_pkg::pwmt_cmd_t  cmd;
    pwmt_pkg::pwmt_stat_t stat;

    // sequencer: dispatch, search, shift, result handoff
    pwmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table ram, count, pending wait and output register
    pwmt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_node_id      (s_node_id),
        .s_tag_value    (s_tag_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_matched_node (m_matched_node),
        .m_matched_tag  (m_matched_tag),
        .m_entries_held (m_entries_held)
    );

endmodule

/* hw/rtl/pwmt_checker.sv */
// port level checker for the post/wait match table, with its bind
module pwmt_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic [6:0] m_entries_held
);

    localparam logic [6:0] FULL_HELD = 7'(TABLE_DEPTH);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entries_held))
        else $error("result changed while stalled");

    // only defined status codes
    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= pwmt_pkg::ST_REJECTED)
        else $error("undefined status code");

    // a stored post leaves at least one entry
    a_posted_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pwmt_pkg::ST_POSTED |-> m_entries_held != 7'd0)
        else $error("post stored but table reads empty");

    // a dropped post only happens on a full table
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == pwmt_pkg::ST_DROPPED |-> m_entries_held == FULL_HELD)
        else $error("post dropped while table not full");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind post_wait_match_table_core pwmt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_pwmt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_entries_held (m_entries_held)
);
